// ===== design/abfs_pkg.sv =====
// Package: constants, sequencer state type and helper functions for the BFS order block.
`default_nettype none
package abfs_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int CFG_W     = 5;

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CFG_W-1:0]     cfg_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEEK,
        ST_DEQ,
        ST_EXPAND
    } state_t;

    // index of the lowest set bit; zero when none set
    function automatic node_t lowest_bit(input row_t vec);
        node_t idx;
        idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                idx = node_t'(i);
            end
        end
        return idx;
    endfunction

    // node count in use: zero acts as one, capped at MAX_NODES
    function automatic cnt_t clamp_count(input cfg_t cfg);
        cnt_t n;
        if (cfg == '0)
        begin
            n = cnt_t'(1);
        end
        else if (32'(cfg) > MAX_NODES)
        begin
            n = cnt_t'(MAX_NODES);
        end
        else
        begin
            n = cnt_t'(cfg);
        end
        return n;
    endfunction

    function automatic row_t count_mask(input cnt_t n);
        row_t m;
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (32'(n) > i);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== design/adjacency_matrix_bfs_order.sv =====
// Top level: loads adjacency rows and emits breadth-first visit order.
//
// Channels: row_valid/row_ready/adj_row carries one adjacency row per transfer,
// row 0 first; bit i set marks an edge to node i. result_valid/result_ready
// carries node_id and last_node, one node per transfer in visit order.
// cfg_valid/cfg_ready/cfg_data writes node_count (1..16, reset 16); a write
// restarts row loading. Write it only while the block is idle.
// Rows are taken one per cycle while the block is loading. After the last row the
// traversal runs with row_ready low: per component ST_SEEK picks its start and
// ST_DEQ later finds its queue empty; per node ST_DEQ dequeues it and ST_EXPAND
// queues each newly found neighbour, picked by the lowest-set-bit encoder, then
// closes its expansion. After the last row the first node passes through ST_SEEK
// and ST_DEQ before it is offered.
// The result sits in an output register, so a stalled receiver only holds the
// dequeue step; nothing is lost. Reset clears the sequencer, counters and
// visited mask; node_count returns to 16.
`default_nettype none
module adjacency_matrix_bfs_order (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  abfs_pkg::cfg_t  cfg_data,
    input  wire                   row_valid,
    output logic                  row_ready,
    input  wire  abfs_pkg::row_t  adj_row,
    output logic                  result_valid,
    input  wire                   result_ready,
    output abfs_pkg::node_t       node_id,
    output logic                  last_node
);
    import abfs_pkg::*;

    state_t state_reg, state_next;
    cfg_t   node_count_reg;
    cnt_t   rows_reg, rows_next;
    cnt_t   emitted_reg, emitted_next;
    cnt_t   head_reg, head_next;
    cnt_t   tail_reg, tail_next;
    row_t   visited_reg, visited_next;
    row_t   fresh_reg, fresh_next;
    row_t   adj_mem_reg [MAX_NODES];
    node_t  queue_reg [MAX_NODES];
    logic   res_valid_reg, res_valid_next;
    node_t  res_node_reg, res_node_next;
    logic   res_last_reg, res_last_next;

    logic   row_we;
    node_t  row_addr;
    logic   q_we;
    node_t  q_data;

    cnt_t   n_use;
    row_t   row_mask;
    cnt_t   row_idx;
    node_t  head_node;
    logic   out_free;
    logic   row_xfer;
    logic   cfg_xfer;

    assign n_use     = clamp_count(node_count_reg);
    assign row_mask  = count_mask(n_use);
    assign row_idx   = (rows_reg >= n_use) ? '0 : rows_reg;
    assign head_node = queue_reg[head_reg[NODE_W-1:0]];
    assign out_free  = !res_valid_reg || result_ready;
    assign row_ready = (state_reg == ST_LOAD);
    assign row_xfer  = row_valid && row_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign result_valid = res_valid_reg;
    assign node_id      = res_node_reg;
    assign last_node    = res_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        emitted_next   = emitted_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        visited_next   = visited_reg;
        fresh_next     = fresh_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_node_next  = res_node_reg;
        res_last_next  = res_last_reg;
        row_we         = 1'b0;
        row_addr       = row_idx[NODE_W-1:0];
        q_we           = 1'b0;
        q_data         = lowest_bit(~visited_reg & row_mask);

        unique case (state_reg)
            ST_LOAD:
            begin
                if (row_xfer)
                begin
                    row_we = 1'b1;
                    if (row_idx + cnt_t'(1) >= n_use)
                    begin
                        rows_next    = '0;
                        visited_next = '0;
                        head_next    = '0;
                        tail_next    = '0;
                        emitted_next = '0;
                        state_next   = ST_SEEK;
                    end
                    else
                    begin
                        rows_next = row_idx + cnt_t'(1);
                    end
                end
                if (cfg_xfer)
                begin
                    rows_next = '0;
                end
            end
            ST_SEEK:
            begin
                // lowest unvisited node starts the next component
                q_we                 = 1'b1;
                tail_next            = tail_reg + cnt_t'(1);
                visited_next[q_data] = 1'b1;
                state_next           = ST_DEQ;
            end
            ST_DEQ:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = (emitted_reg == n_use) ? ST_LOAD : ST_SEEK;
                end
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_node_next  = head_node;
                    res_last_next  = (emitted_reg + cnt_t'(1) == n_use);
                    head_next      = head_reg + cnt_t'(1);
                    emitted_next   = emitted_reg + cnt_t'(1);
                    fresh_next     = adj_mem_reg[head_node] & row_mask & ~visited_reg;
                    state_next     = ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (fresh_reg == '0)
                begin
                    state_next = ST_DEQ;
                end
                else
                begin
                    q_data               = lowest_bit(fresh_reg);
                    q_we                 = 1'b1;
                    tail_next            = tail_reg + cnt_t'(1);
                    visited_next[q_data] = 1'b1;
                    fresh_next[q_data]   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= cfg_t'(MAX_NODES);
            rows_reg       <= '0;
            emitted_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            visited_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                node_count_reg <= cfg_data;
            end
            rows_reg      <= rows_next;
            emitted_reg   <= emitted_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            visited_reg   <= visited_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg    <= fresh_next;
        res_node_reg <= res_node_next;
        res_last_reg <= res_last_next;
        if (row_we)
        begin
            adj_mem_reg[row_addr] <= adj_row;
        end
        if (q_we)
        begin
            queue_reg[tail_reg[NODE_W-1:0]] <= q_data;
        end
    end

endmodule
`default_nettype wire

// ===== verif/bfs_order_checker.sv =====
// Checker for the BFS order block: predicts the visit order and compares every result transfer.
module bfs_order_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  abfs_pkg::cfg_t cfg_data,
    input  logic           row_valid,
    input  logic           row_ready,
    input  abfs_pkg::row_t adj_row,
    input  logic           result_valid,
    input  logic           result_ready,
    input  abfs_pkg::node_t node_id,
    input  logic           last_node,
    output int             errors,
    output int             expected_left,
    output int             graphs_done,
    output int             results_checked
);
    import abfs_pkg::*;

    typedef struct packed {
        node_t id;
        logic  is_last;
    } visit_t;

    cfg_t   count_reg;
    int     rows_held;
    row_t   graph_rows [MAX_NODES];
    visit_t visit_q [$];

    // queue up the expected visit order of the graph now held in graph_rows
    function automatic void bfs_visit_order(input int n);
        row_t   seen;
        node_t  frontier [$];
        node_t  v;
        int     emitted;
        visit_t item;
        seen = '0;
        emitted = 0;
        for (int s = 0; s < n; s++)
        begin
            if (!seen[s])
            begin
                frontier = {frontier, node_t'(s)};
                seen[s] = 1'b1;
                while (frontier.size() > 0)
                begin
                    v = frontier.pop_front();
                    emitted++;
                    item.id = v;
                    item.is_last = (emitted == n);
                    visit_q = {visit_q, item};
                    for (int i = 0; i < n; i++)
                    begin
                        if (graph_rows[v][i] && !seen[i])
                        begin
                            frontier = {frontier, node_t'(i)};
                            seen[i] = 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int     n;
        visit_t want;
        if (!rst_n)
        begin
            count_reg = cfg_t'(MAX_NODES);
            rows_held = 0;
            visit_q.delete();
            errors = 0;
            expected_left = 0;
            graphs_done = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg = cfg_data;
                rows_held = 0;
            end
            if (row_valid && row_ready)
            begin
                // zero acts as one node, anything above the limit as the limit
                n = (count_reg == 0) ? 1 : (count_reg > MAX_NODES) ? MAX_NODES : int'(count_reg);
                if (rows_held >= n)
                    rows_held = 0;
                graph_rows[rows_held] = adj_row;
                rows_held++;
                if (rows_held == n)
                begin
                    rows_held = 0;
                    bfs_visit_order(n);
                    graphs_done++;
                end
            end
            if (result_valid && result_ready)
            begin
                results_checked++;
                if (visit_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual node_id %0d last_node %0b",
                             $time, node_id, last_node);
                    errors++;
                end
                else
                begin
                    want = visit_q.pop_front();
                    if (node_id !== want.id)
                    begin
                        $display("%0t: node_id expected %0d actual %0d",
                                 $time, want.id, node_id);
                        errors++;
                    end
                    if (last_node !== want.is_last)
                    begin
                        $display("%0t: last_node expected %0b actual %0b",
                                 $time, want.is_last, last_node);
                        errors++;
                    end
                end
            end
            expected_left = visit_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: drives adjacency rows, node count writes and result back-pressure; gives the verdict.
module testbench;
    import abfs_pkg::*;

    localparam int ITEMS         = 270;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_SPARSE,
        SHAPE_DENSE,
        SHAPE_UNDIRECTED
    } shape_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_valid;
    logic  cfg_ready;
    cfg_t  cfg_data;
    logic  row_valid;
    logic  row_ready;
    row_t  adj_row;
    logic  result_valid;
    logic  result_ready = 1'b0;
    node_t node_id;
    logic  last_node;

    int    errors;
    int    expected_left;
    int    graphs_done;
    int    results_checked;
    int    rows_sent;
    int    count_writes;
    cfg_t  cur_count;
    bit    no_idle = 1'b0;
    bit    sink_stalled = 1'b0;
    int    sink_left = 0;

    adjacency_matrix_bfs_order dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .adj_row      (adj_row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .node_id      (node_id),
        .last_node    (last_node)
    );

    bfs_order_checker order_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .row_valid       (row_valid),
        .row_ready       (row_ready),
        .adj_row         (adj_row),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .node_id         (node_id),
        .last_node       (last_node),
        .errors          (errors),
        .expected_left   (expected_left),
        .graphs_done     (graphs_done),
        .results_checked (results_checked)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int rows_per_graph(input cfg_t c);
        if (c == 0)
            return 1;
        return (c > MAX_NODES) ? MAX_NODES : int'(c);
    endfunction

    always @(posedge clk)
    begin
        if (sink_left > 0)
            sink_left--;
        else
        begin
            sink_stalled = !sink_stalled && !no_idle;
            sink_left = sink_stalled ? gap_len() : $urandom_range(1, 12);
        end
        result_ready <= rst_n && !sink_stalled;
    end

    task automatic send_row(input row_t row);
        int g;
        row_valid <= 1'b1;
        adj_row <= row;
        do
            @(posedge clk);
        while (!row_ready);
        rows_sent++;
        g = (no_idle || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (g > 0)
        begin
            row_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // hold off until every expected node has arrived and the traversal has wound down
    task automatic settle();
        int k;
        row_valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < DRAIN_LIMIT && expected_left != 0; k++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input cfg_t value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_count = value;
        count_writes++;
    endtask

    task automatic send_graph(input int n, input shape_t shape);
        row_t rows [MAX_NODES];
        row_t above;
        above = ~((row_t'(1) << n) - row_t'(1));
        for (int r = 0; r < n; r++)
        begin
            case (shape)
                SHAPE_RANDOM:
                    rows[r] = row_t'($urandom);
                SHAPE_SPARSE:
                    rows[r] = ($urandom_range(0, 2) == 0) ? '0 :
                              row_t'(1) << $urandom_range(0, n - 1);
                SHAPE_DENSE:
                    rows[r] = row_t'($urandom | $urandom);
                default:
                    rows[r] = row_t'($urandom & $urandom & $urandom);
            endcase
        end
        if (shape == SHAPE_UNDIRECTED)
        begin
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    if (rows[r][c])
                        rows[c][r] = 1'b1;
        end
        // stray edges to absent nodes
        if (shape == SHAPE_SPARSE || shape == SHAPE_UNDIRECTED)
        begin
            for (int r = 0; r < n; r++)
                rows[r] = rows[r] | (row_t'($urandom) & above);
        end
        for (int r = 0; r < n; r++)
            send_row(rows[r]);
    endtask

    initial
    begin
        int  n;
        int  pick;
        bit  abandon;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        row_valid = 1'b0;
        adj_row = '0;
        rows_sent = 0;
        count_writes = 0;
        cur_count = cfg_t'(MAX_NODES);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rows of a half-loaded graph are dropped by the count write
        send_row(16'hFFFF);
        send_row(16'h0000);
        send_row(16'h8001);
        write_count(cfg_t'(3));
        // isolated node 0 forces a restart; edges past the count ignored
        send_row(16'h0000);
        send_row(16'hFFFF);
        send_row(16'h0001);
        write_count(cfg_t'(0));
        send_row(16'hFFFF);
        write_count(cfg_t'(1));
        send_row(16'h0000);
        // count above the limit; node 0 fills the queue, the rest form a ring
        write_count(cfg_t'(31));
        for (int r = 0; r < MAX_NODES; r++)
            send_row((r == 0) ? '1 : ((row_t'(1) << ((r + 1) % MAX_NODES)) |
                                      (row_t'(1) << ((r + MAX_NODES - 1) % MAX_NODES))));

        while (rows_sent < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                n = $urandom_range(1, 6);
            else if (pick < 80)
                n = $urandom_range(7, 12);
            else if (pick < 90)
                n = $urandom_range(13, 16);
            else if (pick < 95)
                n = $urandom_range(17, 31);
            else
                n = 0;
            no_idle = ($urandom_range(0, 5) == 0);
            abandon = ($urandom_range(0, 9) == 0) && (rows_per_graph(cur_count) > 1);
            if (abandon)
            begin
                repeat ($urandom_range(1, rows_per_graph(cur_count) - 1))
                    send_row(row_t'($urandom));
            end
            if (abandon || $urandom_range(0, 3) != 0)
                write_count(cfg_t'(n));
            send_graph(rows_per_graph(cur_count), shape_t'($urandom_range(0, 3)));
        end
        no_idle = 1'b0;
        settle();

        $display("Loaded %0d rows into %0d graphs with %0d node count writes,",
                 rows_sent, graphs_done, count_writes);
        $display("sizes 0 to 31 incl. limit cases; %0d visit results checked.", results_checked);
        if (errors == 0 && expected_left == 0)
            $display("All tests passed");
        else
        begin
            if (expected_left != 0)
                $display("%0t: %0d expected results never arrived", $time, expected_left);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
